FILE: design/fkin_pkg.sv
package fkin_pkg;

  localparam int unsigned AngleBits    = 12;
  localparam int unsigned TrigFracBits = 15;
  localparam int unsigned LenBits      = 16;
  localparam int unsigned OutBits      = 18;
  localparam int unsigned CfgIdxBits   = 8;

  localparam int unsigned QuarterBits  = AngleBits - 2;
  localparam int unsigned Quarter      = 1 << QuarterBits;
  localparam int unsigned TrigAmp      = (1 << TrigFracBits) - 1;

  // one bit more than the quarter offset so that the full quarter index fits
  localparam int unsigned IdxBits  = QuarterBits + 1;
  localparam int unsigned ProdBits = LenBits + TrigFracBits;
  localparam int unsigned TermBits = ProdBits + 1;
  localparam int unsigned SumBits  = TermBits + 1;

  localparam logic [LenBits-1:0] LenReset = LenBits'(2560);

  localparam logic [CfgIdxBits-1:0] CfgFirstLinkLength  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgSecondLinkLength = CfgIdxBits'(1);

  localparam real Pi = 3.14159265358979323846;

  // phase of one table step, a quarter turn spread over the quarter table
  localparam real QuarterStep = Pi / 2.0 / real'(Quarter);

  // magnitude and sign of one table value
  typedef struct packed {
    logic                    neg;
    logic [TrigFracBits-1:0] mag;
  } trig_t;

  typedef logic [TrigFracBits-1:0] qsine_tab_t [0:Quarter];

  // first quarter of round(amp * sin(2*pi*k / full turn)), indexes 0 to quarter
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    real        ph;
    for (int i = 0; i <= int'(Quarter); i++) begin
      ph     = QuarterStep * real'(i);
      tab[i] = TrigFracBits'($rtoi(real'(TrigAmp) * $sin(ph) + 0.5));
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSine = build_qsine();

endpackage

FILE: design/two_link_forward_kinematics.sv
// Planar two-link arm forward kinematics. One pose (two 12-bit binary joint
// angles) is taken on every clock where start is high; busy never rises, so
// poses may stream back to back. Each pose gives end_x_o and end_y_o (signed
// Q10.8) with out_valid_o high for exactly one cycle, after the pose has passed
// the input register, registered sine table read, multiplier register, and sum
// and rounding register. The receiver cannot hold results off, so it must take
// each result in the cycle it is shown. Link lengths are written through the
// cfg port (always ready, unsigned Q8.8, 10.0 after reset); write them only
// while no pose is in flight.
module two_link_forward_kinematics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [fkin_pkg::AngleBits-1:0]        first_joint_angle_i,
  input  logic [fkin_pkg::AngleBits-1:0]        second_joint_angle_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fkin_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [fkin_pkg::LenBits-1:0]          cfg_data_i,
  output logic                                  out_valid_o,
  output logic signed [fkin_pkg::OutBits-1:0]   end_x_o,
  output logic signed [fkin_pkg::OutBits-1:0]   end_y_o
);

  localparam int unsigned AB = fkin_pkg::AngleBits;

  logic [fkin_pkg::LenBits-1:0] len1_q, len2_q;
  logic [AB-1:0]                a1_q, a2_q, a12;
  logic [AB-1:0]                a1_cos, a12_cos;
  logic [3:0]                   vld_q;
  fkin_pkg::trig_t              sin1, cos1, sin12, cos12;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q <= fkin_pkg::LenReset;
      len2_q <= fkin_pkg::LenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fkin_pkg::CfgFirstLinkLength:  len1_q <= cfg_data_i;
        fkin_pkg::CfgSecondLinkLength: len2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      a1_q <= first_joint_angle_i;
      a2_q <= second_joint_angle_i;
    end
  end

  // angle sum wraps at a full turn; cosine is the sine a quarter turn ahead
  assign a12     = a1_q + a2_q;
  assign a1_cos  = a1_q + AB'(fkin_pkg::Quarter);
  assign a12_cos = a12 + AB'(fkin_pkg::Quarter);

  fkin_sine_rom u_rom_first (
    .clk_i     (clk_i),
    .angle_a_i (a1_q),
    .angle_b_i (a1_cos),
    .sine_a_o  (sin1),
    .sine_b_o  (cos1)
  );

  fkin_sine_rom u_rom_sum (
    .clk_i     (clk_i),
    .angle_a_i (a12),
    .angle_b_i (a12_cos),
    .sine_a_o  (sin12),
    .sine_b_o  (cos12)
  );

  fkin_coord u_coord_x (
    .clk_i    (clk_i),
    .len_a_i  (len1_q),
    .len_b_i  (len2_q),
    .trig_a_i (cos1),
    .trig_b_i (cos12),
    .coord_o  (end_x_o)
  );

  fkin_coord u_coord_y (
    .clk_i    (clk_i),
    .len_a_i  (len1_q),
    .len_b_i  (len2_q),
    .trig_a_i (sin1),
    .trig_b_i (sin12),
    .coord_o  (end_y_o)
  );

  assign out_valid_o = vld_q[3];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start, 4))
    else $error("result without a pose four cycles earlier");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (end_x_o <= 18'sd131070) && (end_x_o >= -18'sd131070))
    else $error("end_x out of reachable range");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (end_y_o <= 18'sd131070) && (end_y_o >= -18'sd131070))
    else $error("end_y out of reachable range");

endmodule

FILE: design/fkin_sine_rom.sv
module fkin_sine_rom (
  input  logic                            clk_i,
  input  logic [fkin_pkg::AngleBits-1:0]  angle_a_i,
  input  logic [fkin_pkg::AngleBits-1:0]  angle_b_i,
  output fkin_pkg::trig_t                 sine_a_o,
  output fkin_pkg::trig_t                 sine_b_o
);

  logic [fkin_pkg::IdxBits-1:0] idx_a, idx_b;

  // fold the angle into the first quarter; odd quarters run backward
  always_comb begin
    if (angle_a_i[fkin_pkg::QuarterBits]) begin
      idx_a = fkin_pkg::IdxBits'(fkin_pkg::Quarter)
            - {1'b0, angle_a_i[fkin_pkg::QuarterBits-1:0]};
    end else begin
      idx_a = {1'b0, angle_a_i[fkin_pkg::QuarterBits-1:0]};
    end
    if (angle_b_i[fkin_pkg::QuarterBits]) begin
      idx_b = fkin_pkg::IdxBits'(fkin_pkg::Quarter)
            - {1'b0, angle_b_i[fkin_pkg::QuarterBits-1:0]};
    end else begin
      idx_b = {1'b0, angle_b_i[fkin_pkg::QuarterBits-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    sine_a_o.mag <= fkin_pkg::QSine[idx_a];
    sine_a_o.neg <= angle_a_i[fkin_pkg::AngleBits-1];
    sine_b_o.mag <= fkin_pkg::QSine[idx_b];
    sine_b_o.neg <= angle_b_i[fkin_pkg::AngleBits-1];
  end

endmodule

FILE: design/fkin_coord.sv
module fkin_coord (
  input  logic                                  clk_i,
  input  logic [fkin_pkg::LenBits-1:0]          len_a_i,
  input  logic [fkin_pkg::LenBits-1:0]          len_b_i,
  input  fkin_pkg::trig_t                       trig_a_i,
  input  fkin_pkg::trig_t                       trig_b_i,
  output logic signed [fkin_pkg::OutBits-1:0]   coord_o
);

  localparam int unsigned PB = fkin_pkg::ProdBits;
  localparam int unsigned TB = fkin_pkg::TermBits;
  localparam int unsigned SB = fkin_pkg::SumBits;

  logic [PB-1:0]        prod_a, prod_b;
  logic signed [TB-1:0] term_a_d, term_b_d, term_a_q, term_b_q;
  logic signed [SB-1:0] sum;

  assign prod_a = PB'(len_a_i) * PB'(trig_a_i.mag);
  assign prod_b = PB'(len_b_i) * PB'(trig_b_i.mag);

  assign term_a_d = trig_a_i.neg ? -$signed({1'b0, prod_a}) : $signed({1'b0, prod_a});
  assign term_b_d = trig_b_i.neg ? -$signed({1'b0, prod_b}) : $signed({1'b0, prod_b});

  // round half up, then floor by the arithmetic shift
  assign sum = SB'(term_a_q) + SB'(term_b_q)
             + SB'(1 << (fkin_pkg::TrigFracBits - 1));

  always_ff @(posedge clk_i) begin
    term_a_q <= term_a_d;
    term_b_q <= term_b_d;
    coord_o  <= sum[fkin_pkg::TrigFracBits +: fkin_pkg::OutBits];
  end

endmodule
